>>> rtl/nmbf_pkg.sv
`timescale 1ns / 1ps

package nmbf_pkg;

    // Field widths of the transaction ports
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;
    localparam int COUNT_W  = 8;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Operation codes
    localparam func_t FN_OPEN  = 2'd0;
    localparam func_t FN_CLOSE = 2'd1;
    localparam func_t FN_SEND  = 2'd2;
    localparam func_t FN_RECV  = 2'd3;

    // Status codes
    localparam status_t STAT_OK      = 3'd0;
    localparam status_t STAT_NO_FREE = 3'd1;
    localparam status_t STAT_CLOSED  = 3'd2;
    localparam status_t STAT_FULL    = 3'd3;
    localparam status_t STAT_EMPTY   = 3'd4;

    // Reference count saturates here
    localparam count_t COUNT_MAX = 8'd255;

endpackage

>>> rtl/nmbf_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data
module nmbf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/named_mailbox_byte_fifo.sv
// Bank of named mailboxes, each a circular byte buffer. A transaction is
// accepted when start is high and busy is low; it opens a mailbox by name,
// closes one, sends one byte or receives one byte. Every transaction gives
// exactly one result, shown on the result ports for a single cycle with done
// high; the receiver cannot stall it, so it must take the result in that
// cycle. No new transaction is taken until the last is through: open, close,
// send and failed receives pass through the execute state after the pointer
// memory read; a successful receive then goes on to a read-data state for the
// byte memory read. Name search runs in the accept cycle against all mailboxes
// in parallel. The byte store is not cleared at reset; a receive only reads
// bytes that a send has written.
`timescale 1ns / 1ps

module named_mailbox_byte_fifo #(
    parameter int BOX_COUNT    = 16,
    parameter int BUFFER_BYTES = 64,
    parameter int NAME_BITS    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [nmbf_pkg::FUNC_W-1:0]       func,
    input  logic [nmbf_pkg::KEY_W-1:0]        name_key,
    input  logic [nmbf_pkg::IDX_W-1:0]        box_index,
    input  logic [nmbf_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              last_of_message,
    output logic                              done,
    output logic [nmbf_pkg::STATUS_W-1:0]     status,
    output logic [nmbf_pkg::IDX_W-1:0]        opened_index,
    output logic [nmbf_pkg::BYTE_W-1:0]       data_out,
    output logic [nmbf_pkg::FILL_W-1:0]       fill_level,
    output logic                              message_done
);

    import nmbf_pkg::*;

    localparam int SPAN = 2 * BUFFER_BYTES;
    localparam int PW   = $clog2(SPAN);
    localparam int BW   = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
    localparam int SAW  = $clog2(BOX_COUNT * BUFFER_BYTES);
    localparam int IXW  = BW + IDX_W;
    localparam int FXW  = PW + FILL_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    // Pointer helpers; pointers run modulo twice the buffer size
    function automatic logic [PW-1:0] ptr_adv(input logic [PW-1:0] p);
        return (p == PW'(SPAN - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w,
                                              input logic [PW-1:0] r);
        return (w >= r) ? w - r : w + PW'(SPAN) - r;
    endfunction

    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] p);
        return (p >= PW'(BUFFER_BYTES)) ? p - PW'(BUFFER_BYTES) : p;
    endfunction

    // Control and per-box registers
    logic [1:0]           state_reg, state_next;
    count_t               count_reg [BOX_COUNT];
    logic [NAME_BITS-1:0] name_reg  [BOX_COUNT];

    // Captured transaction
    func_t                func_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic [BW-1:0]        box_reg;
    logic                 box_ok_reg;
    logic                 hit_reg;
    count_t               cnt_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 last_reg;

    // Result registers
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [BW-1:0]        opened_reg, opened_next;
    logic [BYTE_W-1:0]    dout_reg, dout_next;
    logic [PW-1:0]        fill_reg, fill_next;
    logic                 msg_reg, msg_next;

    // Accept-cycle search
    logic                 accept;
    logic [IXW-1:0]       idx_ext;
    logic [BW-1:0]        idx_sel;
    logic                 idx_in_range;
    logic [NAME_BITS-1:0] key_in;
    logic                 hit_any, free_any;
    logic [BW-1:0]        hit_sel, free_sel;
    logic [BW-1:0]        target_box;
    count_t               cnt_sel;
    logic                 box_ok;

    // Memory ports and execute-stage signals
    logic [2*PW-1:0]      ptr_rdata, ptr_wdata;
    logic                 ptr_we;
    logic [PW-1:0]        wp, rp, cur_fill;
    logic                 byte_we, byte_re;
    logic [SAW-1:0]       byte_addr;
    logic [BYTE_W-1:0]    byte_rdata;
    logic                 count_we, name_we;
    count_t               count_wdata;
    logic [IXW-1:0]       opened_ext;
    logic [FXW-1:0]       fill_ext;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Decode the request and search the name table
    always_comb
    begin
        idx_ext      = {{BW{1'b0}}, box_index};
        idx_sel      = idx_ext[BW-1:0];
        idx_in_range = (idx_ext < IXW'(BOX_COUNT));
        key_in       = name_key[NAME_BITS-1:0];
        hit_any      = 1'b0;
        free_any     = 1'b0;
        hit_sel      = '0;
        free_sel     = '0;
        // Descending scan so the lowest index wins
        for (int i = BOX_COUNT - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0 && name_reg[i] == key_in)
            begin
                hit_any = 1'b1;
                hit_sel = BW'(i);
            end
            if (count_reg[i] == '0)
            begin
                free_any = 1'b1;
                free_sel = BW'(i);
            end
        end
        if (func == FN_OPEN)
        begin
            target_box = hit_any ? hit_sel : free_sel;
        end
        else
        begin
            target_box = idx_sel;
        end
        if (func == FN_OPEN || idx_in_range)
        begin
            cnt_sel = count_reg[target_box];
        end
        else
        begin
            cnt_sel = '0;
        end
        if (func == FN_OPEN)
        begin
            box_ok = hit_any || free_any;
        end
        else
        begin
            box_ok = (cnt_sel != '0);
        end
    end

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            key_reg    <= key_in;
            box_reg    <= target_box;
            box_ok_reg <= box_ok;
            hit_reg    <= hit_any;
            cnt_reg    <= cnt_sel;
            byte_reg   <= data_byte;
            last_reg   <= last_of_message;
        end
    end

    // Pointer memory: {write pointer, read pointer} per box
    nmbf_ram #(
        .WIDTH  (2 * PW),
        .DEPTH  (BOX_COUNT),
        .ADDR_W (BW)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (box_reg),
        .wdata (ptr_wdata),
        .re    (accept),
        .raddr (target_box),
        .rdata (ptr_rdata)
    );

    assign wp       = ptr_rdata[2*PW-1:PW];
    assign rp       = ptr_rdata[PW-1:0];
    assign cur_fill = fill_of(wp, rp);

    // Byte store address: box base plus slot of the active pointer
    always_comb
    begin
        byte_addr = SAW'(box_reg) * SAW'(BUFFER_BYTES)
                  + SAW'(slot_of((func_reg == FN_SEND) ? wp : rp));
    end

    nmbf_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (BOX_COUNT * BUFFER_BYTES),
        .ADDR_W (SAW)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_addr),
        .wdata (byte_reg),
        .re    (byte_re),
        .raddr (byte_addr),
        .rdata (byte_rdata)
    );

    // Execute: read-modify-write of one box
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        opened_next = opened_reg;
        dout_next   = dout_reg;
        fill_next   = fill_reg;
        msg_next    = msg_reg;
        ptr_we      = 1'b0;
        ptr_wdata   = {wp, rp};
        byte_we     = 1'b0;
        byte_re     = 1'b0;
        count_we    = 1'b0;
        count_wdata = cnt_reg;
        name_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = STAT_OK;
                opened_next = '0;
                dout_next   = '0;
                fill_next   = '0;
                msg_next    = 1'b0;
                unique case (func_reg)
                    FN_OPEN:
                    begin
                        if (!box_ok_reg)
                        begin
                            status_next = STAT_NO_FREE;
                        end
                        else
                        begin
                            opened_next = box_reg;
                            count_we    = 1'b1;
                            if (hit_reg)
                            begin
                                count_wdata = (cnt_reg == COUNT_MAX) ? cnt_reg
                                                                     : cnt_reg + 1'b1;
                                fill_next   = cur_fill;
                            end
                            else
                            begin
                                // Claim a free box: fresh name, empty buffer
                                count_wdata = count_t'(1);
                                name_we     = 1'b1;
                                ptr_we      = 1'b1;
                                ptr_wdata   = '0;
                            end
                        end
                    end
                    FN_CLOSE:
                    begin
                        if (!box_ok_reg)
                        begin
                            status_next = STAT_CLOSED;
                        end
                        else
                        begin
                            count_we    = 1'b1;
                            count_wdata = cnt_reg - 1'b1;
                            if (cnt_reg == count_t'(1))
                            begin
                                ptr_we    = 1'b1;
                                ptr_wdata = '0;
                            end
                            else
                            begin
                                fill_next = cur_fill;
                            end
                        end
                    end
                    FN_SEND:
                    begin
                        if (!box_ok_reg)
                        begin
                            status_next = STAT_CLOSED;
                        end
                        else if (cur_fill >= PW'(BUFFER_BYTES))
                        begin
                            status_next = STAT_FULL;
                            fill_next   = cur_fill;
                        end
                        else
                        begin
                            byte_we   = 1'b1;
                            ptr_we    = 1'b1;
                            ptr_wdata = {ptr_adv(wp), rp};
                            msg_next  = last_reg;
                            fill_next = cur_fill + 1'b1;
                        end
                    end
                    FN_RECV:
                    begin
                        if (!box_ok_reg)
                        begin
                            status_next = STAT_CLOSED;
                        end
                        else if (cur_fill == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            // Byte comes back next cycle; hold the result
                            byte_re    = 1'b1;
                            ptr_we     = 1'b1;
                            ptr_wdata  = {wp, ptr_adv(rp)};
                            msg_next   = last_reg;
                            fill_next  = cur_fill - 1'b1;
                            done_next  = 1'b0;
                            state_next = S_RDATA;
                        end
                    end
                endcase
            end
            S_RDATA:
            begin
                dout_next  = byte_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < BOX_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (count_we)
            begin
                count_reg[box_reg] <= count_wdata;
            end
        end
    end

    // Names and result payload
    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_reg[box_reg] <= key_reg;
        end
        status_reg <= status_next;
        opened_reg <= opened_next;
        dout_reg   <= dout_next;
        fill_reg   <= fill_next;
        msg_reg    <= msg_next;
    end

    // Result ports
    assign opened_ext   = {{IDX_W{1'b0}}, opened_reg};
    assign fill_ext     = {{FILL_W{1'b0}}, fill_reg};
    assign done         = done_reg;
    assign status       = status_reg;
    assign opened_index = opened_ext[IDX_W-1:0];
    assign data_out     = dout_reg;
    assign fill_level   = fill_ext[FILL_W-1:0];
    assign message_done = msg_reg;

`ifndef SYNTHESIS
    // A result only follows an execute or read-data cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_RDATA))
        else $error("result strobe without a transaction in flight");

    // Every accepted transaction goes straight to execute
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not reach execute");

    // Pointer write-back only happens during execute
    a_ptr_we: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_we |-> (state_reg == S_EXEC))
        else $error("pointer write outside execute");

    // The byte store is never read and written in the same cycle
    a_byte_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_we && byte_re))
        else $error("byte store read and write collide");

    // A successful receive always delivers its result after the data read
    a_recv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |=> done)
        else $error("receive result lost");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nmbf_pkg::*;

    localparam int BOXES     = 16;
    localparam int DEPTH     = 64;
    localparam int RAND_GOAL = 1000;

    typedef struct packed {
        func_t               func;
        logic [KEY_W-1:0]    key;
        logic [IDX_W-1:0]    idx;
        logic [BYTE_W-1:0]   value;
        logic                msg_end;
    } command_t;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    opened;
        logic [BYTE_W-1:0]   data;
        logic [FILL_W-1:0]   fill;
        logic                msg_end;
    } reply_t;

    // Shadow copy of the mailbox bank plus the replies still owed by the block
    class box_bank_shadow;
        logic [KEY_W-1:0]   names  [BOXES];
        count_t             refs   [BOXES];
        logic [FILL_W-1:0]  rd_ptr [BOXES];
        logic [FILL_W-1:0]  wr_ptr [BOXES];
        logic [BYTE_W-1:0]  store  [BOXES][DEPTH];
        reply_t             awaited[$];

        function new();
            foreach (refs[i])
            begin
                names[i]  = '0;
                refs[i]   = '0;
                rd_ptr[i] = '0;
                wr_ptr[i] = '0;
            end
        endfunction

        // Pointers run modulo twice the depth, so a 7-bit difference is the fill
        function logic [FILL_W-1:0] held(logic [IDX_W-1:0] b);
            return wr_ptr[b] - rd_ptr[b];
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function bit pick_live(output logic [IDX_W-1:0] b);
            int live[$];
            foreach (refs[i])
                if (refs[i] != 0)
                    live.push_back(i);
            b = '0;
            if (live.size() == 0)
                return 1'b0;
            b = IDX_W'(live[$urandom_range(0, live.size() - 1)]);
            return 1'b1;
        endfunction

        // Apply one accepted transaction and queue the reply it must produce
        function reply_t take_command(command_t c);
            reply_t r;
            bit     hit;
            int     b;
            r   = '0;
            hit = 1'b0;
            if (c.func == FN_OPEN)
            begin
                // existing name first, then the lowest free box
                for (b = 0; b < BOXES && !hit; b++)
                begin
                    if (refs[b] != 0 && names[b] == c.key)
                    begin
                        if (refs[b] != COUNT_MAX)
                            refs[b]++;
                        r.opened = IDX_W'(b);
                        hit = 1'b1;
                    end
                end
                for (b = 0; b < BOXES && !hit; b++)
                begin
                    if (refs[b] == 0)
                    begin
                        names[b] = c.key;
                        refs[b]  = 8'd1;
                        r.opened = IDX_W'(b);
                        hit = 1'b1;
                    end
                end
                if (hit)
                    r.fill = held(r.opened);
                else
                    r.status = STAT_NO_FREE;
            end
            else if (refs[c.idx] == 0)
            begin
                r.status = STAT_CLOSED;
            end
            else if (c.func == FN_CLOSE)
            begin
                refs[c.idx]--;
                if (refs[c.idx] == 0)
                begin
                    rd_ptr[c.idx] = '0;
                    wr_ptr[c.idx] = '0;
                end
                r.fill = held(c.idx);
            end
            else if (c.func == FN_SEND)
            begin
                if (held(c.idx) >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    store[c.idx][wr_ptr[c.idx][5:0]] = c.value;
                    wr_ptr[c.idx]++;
                    r.msg_end = c.msg_end;
                end
                r.fill = held(c.idx);
            end
            else
            begin
                if (held(c.idx) == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.data = store[c.idx][rd_ptr[c.idx][5:0]];
                    rd_ptr[c.idx]++;
                    r.msg_end = c.msg_end;
                end
                r.fill = held(c.idx);
            end
            awaited.push_back(r);
            return r;
        endfunction

        // Empty string on a match, otherwise a description of the differences
        function string match_reply(reply_t got);
            reply_t exp;
            string  msg;
            msg = "";
            if (awaited.size() == 0)
                return "result with no transaction outstanding";
            exp = awaited.pop_front();
            if (got.status !== exp.status)
                msg = {msg, $sformatf(" status %0d exp %0d", got.status, exp.status)};
            if (got.opened !== exp.opened)
                msg = {msg, $sformatf(" opened_index %0d exp %0d", got.opened, exp.opened)};
            if (got.data !== exp.data)
                msg = {msg, $sformatf(" data_out %0h exp %0h", got.data, exp.data)};
            if (got.fill !== exp.fill)
                msg = {msg, $sformatf(" fill_level %0d exp %0d", got.fill, exp.fill)};
            if (got.msg_end !== exp.msg_end)
                msg = {msg, $sformatf(" message_done %0b exp %0b", got.msg_end, exp.msg_end)};
            return msg;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    func_t                func;
    logic [KEY_W-1:0]     name_key;
    logic [IDX_W-1:0]     box_index;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_of_message;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     opened_index;
    logic [BYTE_W-1:0]    data_out;
    logic [FILL_W-1:0]    fill_level;
    logic                 message_done;

    box_bank_shadow shadow;
    reply_t         last_pred;
    int             errors;
    int             items;
    bit             gaps_on;
    logic [KEY_W-1:0] key_pool [6];

    named_mailbox_byte_fifo u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .name_key        (name_key),
        .box_index       (box_index),
        .data_byte       (data_byte),
        .last_of_message (last_of_message),
        .done            (done),
        .status          (status),
        .opened_index    (opened_index),
        .data_out        (data_out),
        .fill_level      (fill_level),
        .message_done    (message_done)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("testbench: errors");
        $finish;
    end

    task automatic report(string what);
        errors++;
        if (errors <= 100)
            $display("mismatch at %0t:%s", $time, what);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Idle burst with start low and junk on the payload ports
    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            start           = 1'b0;
            func            = func_t'($urandom);
            name_key        = rand_key();
            box_index       = IDX_W'($urandom);
            data_byte       = BYTE_W'($urandom);
            last_of_message = 1'($urandom);
        end
    endtask

    // Present one transaction, hold it until accepted, then predict its reply
    task automatic issue(command_t c);
        @(negedge clk);
        start           = 1'b1;
        func            = c.func;
        name_key        = c.key;
        box_index       = c.idx;
        data_byte       = c.value;
        last_of_message = c.msg_end;
        do
            @(posedge clk);
        while (busy);
        last_pred = shadow.take_command(c);
        items++;
    endtask

    // Fields an operation ignores are filled at random
    task automatic run_op(func_t f, logic [KEY_W-1:0] k, logic [IDX_W-1:0] i,
                          logic [BYTE_W-1:0] v, logic e);
        command_t c;
        c.func    = f;
        c.key     = (f == FN_OPEN) ? k : rand_key();
        c.idx     = (f == FN_OPEN) ? IDX_W'($urandom) : i;
        c.value   = (f == FN_SEND) ? v : BYTE_W'($urandom);
        c.msg_end = (f == FN_SEND || f == FN_RECV) ? e : 1'($urandom);
        if (gaps_on && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 18));
        issue(c);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        reply_t got;
        string  msg;
        if (rst_n && done)
        begin
            got.status  = status;
            got.opened  = opened_index;
            got.data    = data_out;
            got.fill    = fill_level;
            got.msg_end = message_done;
            msg = shadow.match_reply(got);
            if (msg != "")
                report(msg);
        end
    end

    initial
    begin
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] opened_list[$];
        int               n;
        int               k;
        int               first_rand;
        bit               saturated;

        shadow          = new();
        errors          = 0;
        items           = 0;
        gaps_on         = 1'b1;
        saturated       = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        func            = FN_OPEN;
        name_key        = '0;
        box_index       = '0;
        data_byte       = '0;
        last_of_message = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = rand_key();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unused boxes, name match, byte order, empty, last close
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b1);
        run_op(FN_CLOSE, '0, 4'd15, 8'h00, 1'b0);
        run_op(FN_SEND,  '0, 4'd7,  8'h5A, 1'b1);
        run_op(FN_OPEN,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_OPEN,  '1, 4'd0,  8'h00, 1'b0);
        run_op(FN_OPEN,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b1);
        run_op(FN_SEND,  '0, 4'd0,  8'hFF, 1'b1);
        run_op(FN_SEND,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_SEND,  '0, 4'd1,  8'hA5, 1'b1);
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b1);
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_SEND,  '0, 4'd0,  8'h11, 1'b0);
        run_op(FN_OPEN,  '1, 4'd0,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd1,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd1,  8'h00, 1'b0);
        // name stays in box 1 but a dead box never matches: box 0 is claimed
        run_op(FN_OPEN,  '1, 4'd0,  8'h00, 1'b0);
        run_op(FN_RECV,  '0, 4'd0,  8'h00, 1'b0);
        run_op(FN_CLOSE, '0, 4'd0,  8'h00, 1'b0);

        // Random scenarios
        first_rand = items;
        while (items - first_rand < RAND_GOAL)
        begin
            if ($urandom_range(0, 9) == 0)
                gaps_on = !gaps_on;
            if (items - first_rand >= RAND_GOAL - 150)
                gaps_on = 1'b0;

            if (!saturated && items - first_rand >= 100)
            begin
                // Reference count saturation on one fresh name
                saturated = 1'b1;
                opened_list.delete();
                opened_list.push_back('0);
                begin
                    logic [KEY_W-1:0] sat_key;
                    sat_key = rand_key();
                    repeat (258)
                        run_op(FN_OPEN, sat_key, '0, '0, 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 25)
                begin
                    // open from a small pool so names collide, sometimes fresh
                    if ($urandom_range(0, 3) == 0)
                        run_op(FN_OPEN, rand_key(), '0, '0, 1'b0);
                    else
                        run_op(FN_OPEN, key_pool[$urandom_range(0, 5)], '0, '0, 1'b0);
                end
                else if (n < 85 && n >= 75)
                begin
                    if (n < 80)
                    begin
                        // flood one box past full, then drain past empty
                        if (shadow.pick_live(b))
                        begin
                            repeat (66)
                                run_op(FN_SEND, '0, b, BYTE_W'($urandom), 1'($urandom));
                            repeat (66)
                                run_op(FN_RECV, '0, b, '0, 1'($urandom));
                        end
                        else
                            run_op(FN_OPEN, key_pool[0], '0, '0, 1'b0);
                    end
                    else
                    begin
                        // fill the table until no box is free, then release
                        opened_list.delete();
                        repeat (BOXES + 1)
                        begin
                            run_op(FN_OPEN, rand_key(), '0, '0, 1'b0);
                            if (last_pred.status == STAT_OK)
                                opened_list.push_back(last_pred.opened);
                        end
                        foreach (opened_list[j])
                            run_op(FN_CLOSE, '0, opened_list[j], '0, 1'b0);
                    end
                end
                else if (n >= 65 && n < 75)
                begin
                    // noise: anything at all
                    run_op(func_t'($urandom), $urandom_range(0, 1) ? rand_key()
                           : key_pool[$urandom_range(0, 5)], IDX_W'($urandom),
                           BYTE_W'($urandom), 1'($urandom));
                end
                else if (!shadow.pick_live(b))
                begin
                    run_op(FN_OPEN, key_pool[$urandom_range(0, 5)], '0, '0, 1'b0);
                end
                else if (n < 55)
                begin
                    // one message, usually read back
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        run_op(FN_SEND, '0, b, BYTE_W'($urandom), k == n - 1);
                    if ($urandom_range(0, 9) < 7)
                    begin
                        n = n + $urandom_range(0, 2);
                        for (k = 0; k < n; k++)
                            run_op(FN_RECV, '0, b, '0, k == n - 1);
                    end
                end
                else if (n < 65)
                begin
                    if ($urandom_range(0, 3) == 0)
                        run_op(FN_CLOSE, '0, IDX_W'($urandom), '0, 1'b0);
                    else
                        run_op(FN_CLOSE, '0, b, '0, 1'b0);
                end
                else
                begin
                    run_op($urandom_range(0, 1) ? FN_SEND : FN_RECV, '0, b,
                           BYTE_W'($urandom), 1'($urandom));
                end
            end
        end

        // Drain
        @(negedge clk);
        start = 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> named_mailbox_byte_fifo.f
rtl/nmbf_pkg.sv
rtl/nmbf_ram.sv
rtl/named_mailbox_byte_fifo.sv
test/testbench.sv
